FILE: rtl/core/vp_pkg.sv
// ----------------------------------------------------------------------------
// vp_pkg - shared definitions for the Verlet particle step
// Register indexes, reset values, field widths and the structs that pass
// between the coefficient unit, the coordinate lanes and the top level.
// ----------------------------------------------------------------------------
package vp_pkg;

	// Default geometry of one packed coordinate.
	localparam int COORD_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF  = 10;

	// Fixed register widths.
	localparam int DT_W     = 16;
	localparam int GRAV_W   = 20;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 3;
	localparam int K_W      = 32;
	localparam int DT2_W    = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREV_TIME_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCES_ENABLED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CARRY_MODE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Z      = 3'd6;

	// Reset values of the registers.
	localparam int TIME_STEP_RST = 655;
	localparam logic [DT_W-1:0] TIME_STEP_RST_V      = 16'd655;
	localparam logic [DT_W-1:0] PREV_TIME_STEP_RST_V = 16'd0;
	localparam logic            FORCES_ENABLED_RST   = 1'b1;
	localparam logic            CARRY_MODE_RST       = 1'b0;

	// Damping factor one in Q.17 and the derived coefficients after reset.
	localparam int K_ONE = 131072;
	localparam logic [K_W-1:0]   K_RESET   = 32'(K_ONE - TIME_STEP_RST);
	localparam logic [DT2_W-1:0] DT2_RESET = 32'(TIME_STEP_RST * TIME_STEP_RST);

	// Restoring division steps for a 33-bit dividend.
	localparam int DIV_STEPS = 33;

	typedef struct packed {
		logic [K_W-1:0]   k;
		logic [DT2_W-1:0] dt2;
	} coef_t;

	typedef struct packed {
		logic use_carried;
		logic forces_on;
	} lane_ctl_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	typedef enum logic [1:0] {
		KD_IDLE,
		KD_MUL,
		KD_DIV
	} kdiv_state_t;

endpackage

FILE: rtl/core/vp_kdiv.sv
// ----------------------------------------------------------------------------
// vp_kdiv - damping coefficient unit
// Recomputes dt^2 and the damping factor k after a time step register
// changes, with a bit-serial restoring divider for the step ratio.
// ----------------------------------------------------------------------------
module vp_kdiv import vp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DT_W-1:0] dt,
	input  logic [DT_W-1:0] dt_old,
	output coef_t           coef,
	output logic            busy
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	kdiv_state_t state_q, state_n;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_STEPS-1:0] dvd_q;
	logic [DT_W-1:0] rem_q;
	coef_t coef_q;

	logic mul_phase, div_phase, div_last;
	logic [DT_W+1:0] kbase;
	logic [DT_W+17:0] num_full;
	logic [DIV_STEPS-1:0] dvd_init;
	logic [DT_W:0] trial, diff;
	logic ge;
	logic [DT_W-1:0] rem_n;

	assign kbase    = 18'(K_ONE) - {2'b00, dt};
	assign num_full = 34'(kbase) * 34'(dt);
	assign dvd_init = DIV_STEPS'(num_full) + DIV_STEPS'(dt_old >> 1);

	assign trial = {rem_q, dvd_q[DIV_STEPS-1]};
	assign ge    = trial >= {1'b0, dt_old};
	assign diff  = trial - {1'b0, dt_old};
	assign rem_n = ge ? diff[DT_W-1:0] : trial[DT_W-1:0];

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			KD_IDLE: begin
				if (start) state_n = KD_MUL;
			end
			KD_MUL: begin
				if (start) state_n = KD_MUL;
				else if (dt_old == '0) state_n = KD_IDLE;
				else state_n = KD_DIV;
			end
			KD_DIV: begin
				if (start) state_n = KD_MUL;
				else if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_n = KD_IDLE;
			end
			default: state_n = KD_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy      = 1'b0;
		mul_phase = 1'b0;
		div_phase = 1'b0;
		div_last  = 1'b0;
		case (state_q)
			KD_IDLE: begin
				busy = 1'b0;
			end
			KD_MUL: begin
				busy      = 1'b1;
				mul_phase = 1'b1;
			end
			KD_DIV: begin
				busy      = 1'b1;
				div_phase = 1'b1;
				div_last  = cnt_q == CNT_W'(DIV_STEPS - 1);
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= KD_IDLE;
			cnt_q      <= '0;
			coef_q.k   <= K_RESET;
			coef_q.dt2 <= DT2_RESET;
		end else begin
			state_q <= state_n;
			if (mul_phase) begin
				cnt_q      <= '0;
				coef_q.dt2 <= 32'(dt) * 32'(dt);
				if (dt_old == '0) coef_q.k <= 32'(kbase);
			end else if (div_phase) begin
				cnt_q <= cnt_q + 1'b1;
				if (div_last) coef_q.k <= {dvd_q[K_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_phase) begin
			dvd_q <= dvd_init;
			rem_q <= '0;
		end else if (div_phase) begin
			dvd_q <= {dvd_q[DIV_STEPS-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign coef = coef_q;

endmodule

FILE: rtl/core/vp_lane.sv
// ----------------------------------------------------------------------------
// vp_lane - one coordinate of the integration pipeline
// Stages one to four: velocity base and acceleration, the two products,
// rounding with the clamped shift, then next position and squared shift.
// ----------------------------------------------------------------------------
module vp_lane import vp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                       clk,
	input  pipe_en_t                   en,
	input  lane_ctl_t                  ctl,
	input  coef_t                      coef,
	input  logic [COORD_BITS-1:0]      cur,
	input  logic [COORD_BITS-1:0]      prev,
	input  logic [COORD_BITS-1:0]      frc,
	input  logic [COORD_BITS-1:0]      car,
	input  logic signed [GRAV_W-1:0]   grav,
	output logic [COORD_BITS-1:0]      nx,
	output logic [COORD_BITS-1:0]      sh,
	output logic [2*COORD_BITS-1:0]    sq,
	output logic                       sat
);

	localparam int C   = COORD_BITS;
	localparam int AW  = ((C > GRAV_W) ? C : GRAV_W) + 1;
	localparam int BW  = C + 1;
	localparam int P1W = BW + K_W + 1;
	localparam int P2W = AW + DT2_W + 1;
	localparam int SW  = ((P1W > P2W) ? P1W : P2W) + 1;

	localparam logic signed [SW-1:0] SH_HI = signed'(SW'({(C-1){1'b1}}));
	localparam logic signed [SW-1:0] SH_LO = ~SH_HI;
	localparam logic signed [C:0]    NX_HI = signed'((C+1)'({(C-1){1'b1}}));
	localparam logic signed [C:0]    NX_LO = ~NX_HI;

	logic hold;
	assign hold = ctl.use_carried && !ctl.forces_on;

	// Stage 1: velocity base and total acceleration.
	logic signed [C-1:0] cur_v, prev_v, frc_v, car_v;
	logic signed [BW-1:0] base_c;
	logic signed [AW-1:0] acc_c;
	logic [C-1:0] cur_s1;
	logic signed [BW-1:0] base_s1;
	logic signed [AW-1:0] acc_s1;

	assign cur_v  = signed'(cur);
	assign prev_v = signed'(prev);
	assign frc_v  = signed'(frc);
	assign car_v  = signed'(car);
	assign base_c = (ctl.use_carried && ctl.forces_on) ? BW'(car_v)
	              : BW'(cur_v) - BW'(prev_v);
	assign acc_c  = ctl.forces_on ? AW'(frc_v) + AW'(grav) : '0;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			cur_s1  <= cur;
			base_s1 <= base_c;
			acc_s1  <= acc_c;
		end
	end

	// Stage 2: damped term and force term products.
	logic [C-1:0] cur_s2;
	logic signed [P1W-1:0] p1_s2;
	logic signed [P2W-1:0] p2_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cur_s2 <= cur_s1;
			p1_s2  <= $signed({1'b0, coef.k}) * base_s1;
			p2_s2  <= acc_s1 * $signed({1'b0, coef.dt2});
		end
	end

	// Stage 3: round each term half up, add, clamp.
	logic signed [P1W-1:0] p1r, t1;
	logic signed [P2W-1:0] p2r, t2;
	logic signed [SW-1:0] sum_c;
	logic [C-1:0] sh_c;
	logic shsat_c;
	logic [C-1:0] cur_s3, sh_s3;
	logic shsat_s3;

	assign p1r   = p1_s2 + $signed(P1W'(1) << 16);
	assign t1    = p1r >>> 17;
	assign p2r   = p2_s2 + $signed(P2W'(1) << 31);
	assign t2    = p2r >>> 32;
	assign sum_c = SW'(t1) + SW'(t2);

	always_comb begin
		shsat_c = 1'b0;
		sh_c    = sum_c[C-1:0];
		if (sum_c > SH_HI) begin
			shsat_c = 1'b1;
			sh_c    = SH_HI[C-1:0];
		end else if (sum_c < SH_LO) begin
			shsat_c = 1'b1;
			sh_c    = SH_LO[C-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			cur_s3   <= cur_s2;
			sh_s3    <= sh_c;
			shsat_s3 <= shsat_c;
		end
	end

	// Stage 4: next position and squared shift.
	logic signed [C:0] nsum;
	logic [C-1:0] nx_c;
	logic nxsat_c;
	logic signed [2*C-1:0] sq_full;
	logic [C-1:0] nx_s4, sh_s4;
	logic [2*C-1:0] sq_s4;
	logic sat_s4;

	assign nsum    = (C+1)'(signed'(cur_s3)) + (C+1)'(signed'(sh_s3));
	assign sq_full = signed'(sh_s3) * signed'(sh_s3);

	always_comb begin
		nxsat_c = 1'b0;
		nx_c    = nsum[C-1:0];
		if (hold) begin
			nx_c = cur_s3;
		end else if (nsum > NX_HI) begin
			nxsat_c = 1'b1;
			nx_c    = NX_HI[C-1:0];
		end else if (nsum < NX_LO) begin
			nxsat_c = 1'b1;
			nx_c    = NX_LO[C-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			nx_s4  <= nx_c;
			sh_s4  <= sh_s3;
			sq_s4  <= unsigned'(sq_full);
			sat_s4 <= shsat_s3 | nxsat_c;
		end
	end

	assign nx  = nx_s4;
	assign sh  = sh_s4;
	assign sq  = sq_s4;
	assign sat = sat_s4;

endmodule

FILE: rtl/core/verlet_particle_step.sv
// ----------------------------------------------------------------------------
// verlet_particle_step - damped position Verlet step, one particle per item
// Five-stage streaming datapath over three coordinate lanes, with a
// configuration register file and a coefficient unit for the damping factor.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                      Contents
// s_axis    in         tvalid tready tdata tlast    particle state, last flag
// m_axis    out        tvalid tready tdata tlast    next position, shift, flags
// cfg       in         cfg_we cfg_index cfg_wdata   register writes, no wait
//
// One particle enters per cycle while s_axis_tready is high; its result
// leaves from the output register; throughput is one transfer per cycle when nothing stalls.
// A write to time_step or previous_time_step holds off input transfers
// while the coefficient unit works: the multiply step alone when
// previous_time_step is zero, otherwise also its 33-step bit-serial divider.
// Each stage holds while the next one is full and stalled, so bubbles close
// up and input transfers continue while a result waits on m_axis_tready.
// Reset clears the valid bits and loads the register reset values; no
// memory is cleared.
//
module verlet_particle_step import vp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// Fields from bit 0 up: current_position, previous_position, force_req,
	// carried_shift (each three coordinates), attached_in, zero padding.
	input  logic [((12*COORD_BITS+1+7)/8)*8-1:0] s_axis_tdata,
	input  logic                 s_axis_tlast,
	// Output stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// Fields from bit 0 up: next_position, shift_out (each three
	// coordinates), attached_out, saturated, zero padding.
	output logic [((6*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata,
	output logic                 m_axis_tlast,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int C       = COORD_BITS;
	localparam int OUT_RAW = 6*C + 2;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
	localparam int SQW     = 2*C + 2;
	// The squared length exceeds 0.001 exactly when sum(s^2) > 2^(2F) / 1000.
	localparam longint unsigned SQ_THR = (64'd1 << (2*FRAC_BITS)) / 1000;

	// ---------------------------------------------------------------------
	// Configuration registers. A write to either time step register starts
	// the coefficient unit in the following cycle, once the new value sits.
	// ---------------------------------------------------------------------
	logic [DT_W-1:0] time_step_q, prev_step_q;
	logic forces_q, carry_q;
	logic signed [GRAV_W-1:0] grav_q [3];
	logic start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST_V;
			prev_step_q <= PREV_TIME_STEP_RST_V;
			forces_q    <= FORCES_ENABLED_RST;
			carry_q     <= CARRY_MODE_RST;
			grav_q[0]   <= '0;
			grav_q[1]   <= '0;
			grav_q[2]   <= '0;
			start_q     <= 1'b0;
		end else begin
			start_q <= cfg_we &&
			           (cfg_index == CFG_TIME_STEP || cfg_index == CFG_PREV_TIME_STEP);
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIME_STEP:      time_step_q <= cfg_wdata[DT_W-1:0];
					CFG_PREV_TIME_STEP: prev_step_q <= cfg_wdata[DT_W-1:0];
					CFG_FORCES_ENABLED: forces_q    <= cfg_wdata[0];
					CFG_CARRY_MODE:     carry_q     <= cfg_wdata[0];
					CFG_GRAVITY_X:      grav_q[0]   <= signed'(cfg_wdata[GRAV_W-1:0]);
					CFG_GRAVITY_Y:      grav_q[1]   <= signed'(cfg_wdata[GRAV_W-1:0]);
					CFG_GRAVITY_Z:      grav_q[2]   <= signed'(cfg_wdata[GRAV_W-1:0]);
					default: ;
				endcase
			end
		end
	end

	// Coefficient unit: k in Q.17 and dt^2 in Q0.32.
	coef_t coef;
	logic kd_busy;

	vp_kdiv u_kdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.dt     (time_step_q),
		.dt_old (prev_step_q),
		.coef   (coef),
		.busy   (kd_busy)
	);

	// ---------------------------------------------------------------------
	// Stage control. A stage loads when it is empty or when the stage after
	// it loads in the same cycle; the last stage is the output register.
	// ---------------------------------------------------------------------
	pipe_en_t en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic in_xfer;

	assign en.s5 = !v_s5 || m_axis_tready;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign s_axis_tready = en.s1 && !kd_busy && !start_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_xfer;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	// Per-item flags that ride alongside the lanes.
	logic att_s1, att_s2, att_s3, att_s4;
	logic last_s1, last_s2, last_s3, last_s4;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			att_s1  <= s_axis_tdata[12*C];
			last_s1 <= s_axis_tlast;
		end
		if (en.s2) begin
			att_s2  <= att_s1;
			last_s2 <= last_s1;
		end
		if (en.s3) begin
			att_s3  <= att_s2;
			last_s3 <= last_s2;
		end
		if (en.s4) begin
			att_s4  <= att_s3;
			last_s4 <= last_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Coordinate lanes, x in the low slot of each packed field.
	// ---------------------------------------------------------------------
	lane_ctl_t ctl;
	assign ctl.use_carried = carry_q;
	assign ctl.forces_on   = forces_q;

	logic [C-1:0] nx_l [3];
	logic [C-1:0] sh_l [3];
	logic [2*C-1:0] sq_l [3];
	logic [2:0] sat_l;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vp_lane #(
			.COORD_BITS (COORD_BITS)
		) u_lane (
			.clk  (clk),
			.en   (en),
			.ctl  (ctl),
			.coef (coef),
			.cur  (s_axis_tdata[i*C +: C]),
			.prev (s_axis_tdata[3*C + i*C +: C]),
			.frc  (s_axis_tdata[6*C + i*C +: C]),
			.car  (s_axis_tdata[9*C + i*C +: C]),
			.grav (grav_q[i]),
			.nx   (nx_l[i]),
			.sh   (sh_l[i]),
			.sq   (sq_l[i]),
			.sat  (sat_l[i])
		);
	end

	// ---------------------------------------------------------------------
	// Stage 5: squared shift length against the motion threshold, and the
	// output register.
	// ---------------------------------------------------------------------
	logic [SQW-1:0] sq_sum;
	logic moved;
	logic [3*C-1:0] npos_s5, nshift_s5;
	logic att_s5, sat_s5, last_s5;

	assign sq_sum = SQW'(sq_l[0]) + SQW'(sq_l[1]) + SQW'(sq_l[2]);
	assign moved  = 64'(sq_sum) > SQ_THR;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			npos_s5   <= {nx_l[2], nx_l[1], nx_l[0]};
			nshift_s5 <= {sh_l[2], sh_l[1], sh_l[0]};
			att_s5    <= att_s4 && !moved;
			sat_s5    <= |sat_l;
			last_s5   <= last_s4;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = OUT_W'({sat_s5, att_s5, nshift_s5, npos_s5});
	assign m_axis_tlast  = last_s5;

`ifndef SYNTHESIS
	// An accepted transfer always occupies stage one in the next cycle.
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> v_s1)
		else $error("accepted transfer did not reach stage one");

	// A full stage four behind a stalled output register keeps its item.
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en.s5 |=> v_s4)
		else $error("stage four item lost during output stall");

	// No input transfer in the cycle after a time step register write.
	a_coef_guard: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == CFG_TIME_STEP || cfg_index == CFG_PREV_TIME_STEP)
		|=> !s_axis_tready)
		else $error("input accepted while damping coefficient is stale");
`endif

endmodule

FILE: sim/verlet_particle_step_tb.sv
// ----------------------------------------------------------------------------
// verlet_particle_step_tb - self-checking bench for the Verlet particle step
// Streams particles through the block under a series of register settings,
// predicts every result with its own fixed-point model of the damped step
// and compares each output transfer field by field, in order.
// ----------------------------------------------------------------------------
module verlet_particle_step_tb;
	import vp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Coordinate geometry used by the bench; it matches the default build.
	localparam int COORD_W = 20;
	localparam int FRAC_W  = 10;
	localparam int POS_W   = 3 * COORD_W;
	localparam int S_W     = ((12 * COORD_W + 1 + 7) / 8) * 8;
	localparam int M_W     = ((6 * COORD_W + 2 + 7) / 8) * 8;

	localparam logic [COORD_W-1:0] C_MAX = 20'h7FFFF;
	localparam logic [COORD_W-1:0] C_MIN = 20'h80000;

	// Damping factor one in Q.17.
	localparam longint K_UNITY = 131072;

	// An index the register file does not decode; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

	// Coordinate styles for random stimulus.
	localparam int STY_ANY    = 0;
	localparam int STY_CORNER = 1;
	localparam int STY_NEAR0  = 2;
	localparam int STY_MIXED  = 3;

	// Idle cycles allowed after the last expected result before a register
	// write; the datapath is five stages deep.
	localparam int DRAIN_SLACK = 10;
	// Cycles with no transfer and no register write before the run is abandoned.
	localparam int STALL_LIMIT = 3000;

	localparam int RANDOM_PER_PHASE = 175;
	localparam int NUM_PHASES       = 10;

	typedef struct {
		logic [POS_W-1:0] cur;
		logic [POS_W-1:0] prev;
		logic [POS_W-1:0] frc;
		logic [POS_W-1:0] carried;
		logic             attached;
		logic             last;
		bit               drain; // hold this particle until the pipe is empty
	} particle_t;

	typedef struct {
		logic [POS_W-1:0] nxt_pos;
		logic [POS_W-1:0] shift;
		logic             attached;
		logic             sat;
		logic             last;
	} step_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// From bit 0 up: current_position, previous_position, force_req,
	// carried_shift, attached_in, zero padding.
	logic [S_W-1:0]   s_axis_tdata  = '0;
	logic             s_axis_tlast  = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// From bit 0 up: next_position, shift_out, attached_out, saturated,
	// zero padding.
	logic [M_W-1:0]   m_axis_tdata;
	logic             m_axis_tlast;
	logic             cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata     = '0;

	// Bench copy of the register file, updated as each write goes out.
	logic [DT_W-1:0]          dt_reg     = 16'd655;
	logic [DT_W-1:0]          dt_old_reg = 16'd0;
	logic                     forces_reg = 1'b1;
	logic                     carry_reg  = 1'b0;
	logic signed [GRAV_W-1:0] grav_reg [3] = '{20'sd0, 20'sd0, 20'sd0};

	particle_t    pending_particles[$];
	step_result_t expected_steps[$];

	int send_idle_pct = 25;
	int recv_idle_pct = 55;
	int error_count   = 0;
	int result_count  = 0;
	int stall_cycles  = 0;

	step_result_t want_r;

	verlet_particle_step u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Fixed-point model of one damped Verlet step.
	// ------------------------------------------------------------------------

	function automatic longint coord_of(logic [POS_W-1:0] packed_v, int i);
		logic signed [COORD_W-1:0] c;
		c = packed_v[i*COORD_W +: COORD_W];
		return longint'(c);
	endfunction

	// Rounds half up: floor(v / 2^s + 1/2).
	function automatic longint round_shift(longint v, int s);
		longint one;
		one = 1;
		return (v + (one << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_coord(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (COORD_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic step_result_t compute_verlet_step(particle_t p);
		step_result_t r;
		longint dt2;
		longint k;
		longint cur;
		longint base;
		longint sh;
		longint nx;
		longint clamped;
		longint sq;
		bit     sat;
		bit     carried_base;
		bit     hold_pos;
		dt2 = longint'(dt_reg) * longint'(dt_reg);
		k = K_UNITY - longint'(dt_reg);
		// A nonzero previous step scales the damping by the step ratio.
		if (dt_old_reg != 0) begin
			k = (k * longint'(dt_reg) + longint'(dt_old_reg >> 1)) / longint'(dt_old_reg);
		end
		// The carried shift only stands in for the velocity when forces are on;
		// carried mode without forces keeps the particle where it is.
		carried_base = carry_reg && forces_reg;
		hold_pos = carry_reg && !forces_reg;
		sat = 1'b0;
		sq = 0;
		r.nxt_pos = '0;
		r.shift = '0;
		for (int i = 0; i < 3; i++) begin
			cur = coord_of(p.cur, i);
			base = carried_base ? coord_of(p.carried, i) : cur - coord_of(p.prev, i);
			sh = round_shift(k * base, 17);
			if (forces_reg) begin
				sh += round_shift((coord_of(p.frc, i) + longint'(grav_reg[i])) * dt2, 32);
			end
			clamped = clamp_coord(sh);
			sat |= (clamped != sh);
			sh = clamped;
			if (hold_pos) begin
				nx = cur;
			end else begin
				nx = clamp_coord(cur + sh);
				sat |= (nx != cur + sh);
			end
			sq += sh * sh;
			r.shift[i*COORD_W +: COORD_W] = sh[COORD_W-1:0];
			r.nxt_pos[i*COORD_W +: COORD_W] = nx[COORD_W-1:0];
		end
		// The particle stays attached unless its squared move exceeds 0.001.
		r.attached = p.attached && !(sq * 1000 > (longint'(1) << (2 * FRAC_W)));
		r.sat = sat;
		r.last = p.last;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------

	function automatic logic [POS_W-1:0] pack3(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z);
		return {z, y, x};
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord(int style);
		case (style)
			STY_ANY: begin
				return COORD_W'($urandom);
			end
			STY_CORNER: begin
				case ($urandom_range(4))
					0: return C_MAX;
					1: return C_MIN;
					2: return '0;
					3: return 20'd1;
					default: return '1;
				endcase
			end
			default: begin
				return COORD_W'($urandom_range(0, 255) - 128);
			end
		endcase
	endfunction

	function automatic logic [POS_W-1:0] rand_packed(int style);
		logic [POS_W-1:0] v;
		for (int i = 0; i < 3; i++) begin
			v[i*COORD_W +: COORD_W] =
				rand_coord(style == STY_MIXED ? int'($urandom_range(2)) : style);
		end
		return v;
	endfunction

	// Each coordinate of base moved by up to +-span; spans near the attach
	// threshold put the attached flag on both sides of it.
	function automatic logic [POS_W-1:0] offset_packed(logic [POS_W-1:0] base, int span);
		logic [POS_W-1:0] v;
		for (int i = 0; i < 3; i++) begin
			v[i*COORD_W +: COORD_W] = base[i*COORD_W +: COORD_W]
				+ COORD_W'($urandom_range(0, 2 * span) - span);
		end
		return v;
	endfunction

	task automatic add_particle(logic [POS_W-1:0] cur, logic [POS_W-1:0] prev,
			logic [POS_W-1:0] frc, logic [POS_W-1:0] carried, logic attached, logic last,
			bit drain = 1'b0);
		particle_t p;
		p.cur = cur;
		p.prev = prev;
		p.frc = frc;
		p.carried = carried;
		p.attached = attached;
		p.last = last;
		p.drain = drain;
		pending_particles.push_back(p);
	endtask

	task automatic add_random_particle(bit drain);
		logic [POS_W-1:0] cur;
		logic [POS_W-1:0] prev;
		logic [POS_W-1:0] frc;
		logic [POS_W-1:0] carried;
		int unsigned      pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			// A particle that barely moves: the common case in a settled system.
			cur = rand_packed(STY_ANY);
			prev = offset_packed(cur, 48);
			frc = rand_packed(STY_NEAR0);
			carried = offset_packed('0, 48);
		end else if (pick < 75) begin
			cur = rand_packed(STY_ANY);
			prev = rand_packed(STY_ANY);
			frc = rand_packed(STY_ANY);
			carried = rand_packed(STY_ANY);
		end else if (pick < 90) begin
			cur = rand_packed(STY_CORNER);
			prev = rand_packed(STY_CORNER);
			frc = rand_packed(STY_CORNER);
			carried = rand_packed(STY_CORNER);
		end else begin
			cur = rand_packed(STY_MIXED);
			prev = rand_packed(STY_MIXED);
			frc = rand_packed(STY_MIXED);
			carried = rand_packed(STY_MIXED);
		end
		add_particle(cur, prev, frc, carried, $urandom_range(3) != 0,
			$urandom_range(7) == 0, drain);
	endtask

	// One register write. Bits above a register's width carry junk, which the
	// block must drop; the bench copy keeps only the decoded bits.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TIME_STEP:      dt_reg = val[DT_W-1:0];
			CFG_PREV_TIME_STEP: dt_old_reg = val[DT_W-1:0];
			CFG_FORCES_ENABLED: forces_reg = val[0];
			CFG_CARRY_MODE:     carry_reg = val[0];
			CFG_GRAVITY_X:      grav_reg[0] = val;
			CFG_GRAVITY_Y:      grav_reg[1] = val;
			CFG_GRAVITY_Z:      grav_reg[2] = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [DT_W-1:0] dt, logic [DT_W-1:0] dt_old, logic forces,
			logic carry, logic [GRAV_W-1:0] gx, logic [GRAV_W-1:0] gy, logic [GRAV_W-1:0] gz);
		write_reg(CFG_TIME_STEP, {4'($urandom), dt});
		write_reg(CFG_PREV_TIME_STEP, {4'($urandom), dt_old});
		write_reg(CFG_FORCES_ENABLED, {19'($urandom), forces});
		write_reg(CFG_CARRY_MODE, {19'($urandom), carry});
		write_reg(CFG_GRAVITY_X, gx);
		write_reg(CFG_GRAVITY_Y, gy);
		write_reg(CFG_GRAVITY_Z, gz);
		write_reg(CFG_NO_REG, CFG_W'($urandom));
	endtask

	// Returns once every particle has been accepted and every result seen,
	// plus the DRAIN_SLACK wait so the pipe is certainly empty.
	task automatic wait_pipe_empty();
		while (pending_particles.size() != 0 || expected_steps.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
		$display("result %0d: %s mismatch, got %h expected %h", result_count, what, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------------
	// Input driver. A presented particle is held until its transfer; a new one
	// is offered only after that, subject to random idling and, for a particle
	// marked to drain, until every outstanding result has come back.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_steps.push_back(compute_verlet_step(pending_particles[0]));
				void'(pending_particles.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_particles.size() != 0
						&& !(pending_particles[0].drain && expected_steps.size() != 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= S_W'({pending_particles[0].attached,
						pending_particles[0].carried, pending_particles[0].frc,
						pending_particles[0].prev, pending_particles[0].cur});
					s_axis_tlast <= pending_particles[0].last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output monitor. Randomizes backpressure, checks each output transfer
	// against the oldest expectation and keeps the stall count for the
	// watchdog.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_cycles <= 0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_steps.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[POS_W-1:0], '0);
				end else begin
					want_r = expected_steps.pop_front();
					if (m_axis_tdata[POS_W-1:0] !== want_r.nxt_pos) begin
						report_mismatch("next_position", m_axis_tdata[POS_W-1:0],
							want_r.nxt_pos);
					end
					if (m_axis_tdata[2*POS_W-1:POS_W] !== want_r.shift) begin
						report_mismatch("shift_out", m_axis_tdata[2*POS_W-1:POS_W],
							want_r.shift);
					end
					if (m_axis_tdata[2*POS_W] !== want_r.attached) begin
						report_mismatch("attached_out", POS_W'(m_axis_tdata[2*POS_W]),
							POS_W'(want_r.attached));
					end
					if (m_axis_tdata[2*POS_W+1] !== want_r.sat) begin
						report_mismatch("saturated", POS_W'(m_axis_tdata[2*POS_W+1]),
							POS_W'(want_r.sat));
					end
					if (m_axis_tlast !== want_r.last) begin
						report_mismatch("last", POS_W'(m_axis_tlast), POS_W'(want_r.last));
					end
					if (m_axis_tdata[M_W-1:2*POS_W+2] !== '0) begin
						report_mismatch("padding", POS_W'(m_axis_tdata[M_W-1:2*POS_W+2]), '0);
					end
				end
				result_count++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| cfg_we) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Watchdog: a run that stops moving is a failure.
	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		logic [DT_W-1:0]   dt_v;
		logic [DT_W-1:0]   old_v;
		logic              frc_v;
		logic              carry_v;
		logic [GRAV_W-1:0] gx;
		logic [GRAV_W-1:0] gy;
		logic [GRAV_W-1:0] gz;
		int                drain_at;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed particles under the reset settings: field extremes,
		// saturation of shift and position, both sides of the attach
		// threshold, and the last marker.
		add_particle('0, '0, '0, '0, 1'b1, 1'b0);
		add_particle(pack3(C_MAX, C_MAX, C_MAX), pack3(C_MIN, C_MIN, C_MIN), '0, '0, 1'b1, 1'b0);
		add_particle(pack3(C_MIN, C_MIN, C_MIN), pack3(C_MAX, C_MAX, C_MAX), '0, '0, 1'b1, 1'b0);
		add_particle('0, '0, pack3(C_MAX, C_MAX, C_MAX), pack3(C_MAX, C_MAX, C_MAX), 1'b1, 1'b0);
		add_particle('0, '0, pack3(C_MIN, C_MIN, C_MIN), pack3(C_MIN, C_MIN, C_MIN), 1'b1, 1'b0);
		// A move of 30 stays under the threshold, a move of 34 crosses it.
		add_particle(pack3(20'd100, '0, '0), pack3(20'd70, '0, '0), '0, '0, 1'b1, 1'b0);
		add_particle(pack3(20'd100, '0, '0), pack3(20'd66, '0, '0), '0, '0, 1'b1, 1'b0);
		add_particle(pack3(20'd100, '0, '0), pack3(20'd66, '0, '0), '0, '0, 1'b0, 1'b0);
		add_particle(pack3(C_MAX, C_MIN, 20'd1), pack3(20'd1, '1, C_MAX),
			pack3(C_MIN, C_MAX, '0), '1, 1'b1, 1'b1);
		add_particle(pack3(C_MAX, C_MAX, C_MAX), '0, pack3(C_MAX, C_MAX, C_MAX), '0, 1'b1, 1'b0);
		add_particle('1, '1, '1, '1, 1'b1, 1'b1);
		add_particle(pack3(-20'sd5, 20'sd5, '0), pack3(20'sd5, -20'sd5, '0), '0,
			pack3(20'd1, 20'd1, 20'd1), 1'b0, 1'b1);
		wait_pipe_empty();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// Three idling regimes: sender light and receiver heavy, then the
			// reverse, then free flow.
			if (ph < 4) begin
				send_idle_pct = 25;
				recv_idle_pct = 55;
			end else if (ph < 7) begin
				send_idle_pct = 55;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			gx = COORD_W'($urandom_range(0, 65535) - 32768);
			gy = COORD_W'($urandom_range(0, 65535) - 32768);
			gz = COORD_W'($urandom_range(0, 65535) - 32768);
			case (ph)
				0: begin
					// Reset values written back explicitly.
					dt_v = 16'd655; old_v = 16'd0; frc_v = 1'b1; carry_v = 1'b0;
					gx = '0; gy = '0; gz = '0;
				end
				1: begin
					// Zero step: unit damping and no force contribution.
					dt_v = 16'd0; old_v = 16'd0; frc_v = 1'b1; carry_v = 1'b0;
					gx = C_MAX; gy = C_MIN;
				end
				2: begin
					dt_v = 16'hFFFF; old_v = 16'd0; frc_v = 1'b1; carry_v = 1'b0;
				end
				3: begin
					// Largest step ratio, in carried mode.
					dt_v = 16'hFFFF; old_v = 16'd1; frc_v = 1'b1; carry_v = 1'b1;
				end
				4: begin
					dt_v = 16'd1000; old_v = 16'hFFFF; frc_v = 1'b0; carry_v = 1'b0;
				end
				5: begin
					// Carried mode without forces: the position must not move.
					dt_v = 16'd655; old_v = 16'd655; frc_v = 1'b0; carry_v = 1'b1;
				end
				6: begin
					dt_v = 16'd3000; old_v = 16'd0; frc_v = 1'b1; carry_v = 1'b1;
					gx = C_MIN; gy = C_MAX; gz = '0;
				end
				default: begin
					case ($urandom_range(3))
						0: dt_v = DT_W'($urandom_range(0, 2000));
						1: dt_v = DT_W'($urandom);
						2: dt_v = 16'd655;
						default: dt_v = DT_W'($urandom_range(60000, 65535));
					endcase
					old_v = ($urandom_range(1) == 0) ? 16'd0 : DT_W'($urandom_range(1, 65535));
					frc_v = 1'($urandom_range(1));
					carry_v = 1'($urandom_range(1));
				end
			endcase
			apply_settings(dt_v, old_v, frc_v, carry_v, gx, gy, gz);

			// One particle per phase waits for the pipe to run dry first.
			drain_at = $urandom_range(RANDOM_PER_PHASE / 4, RANDOM_PER_PHASE - 1);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				add_random_particle(n == drain_at);
			end
			wait_pipe_empty();
		end

		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
